[rtl/htc_pkg.sv]
`default_nettype none

package htc_pkg;

    localparam int MAX_NODES_DEFAULT = 256;

    localparam int IDX_W  = 8;
    localparam int ROT_W  = 64;
    localparam int SCL_W  = 48;
    localparam int POS_W  = 60;
    localparam int COMP_W = 20;

    // identity w component, 1.0 in q1.14
    localparam logic [15:0] ROT_ONE = 16'h4000;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [SCL_W-1:0] scl;
        logic [ROT_W-1:0] rot;
    } xform_t;

    // request to the normalizer: four raw product components, w in the low bits
    typedef struct packed {
        logic              start;
        logic [4*COMP_W-1:0] comps;
    } norm_req_t;

    typedef struct packed {
        logic             done;
        logic             fault;
        logic [ROT_W-1:0] rot;
    } norm_rsp_t;

endpackage

`default_nettype wire

[rtl/htc_if.sv]
`default_nettype none

interface htc_node_if;
    import htc_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] node_index;
    logic [IDX_W-1:0] parent_index;
    logic             has_parent;
    logic [ROT_W-1:0] local_rotation;
    logic [SCL_W-1:0] local_scale;
    logic [POS_W-1:0] local_position;

    modport source (
        output valid, node_index, parent_index, has_parent,
               local_rotation, local_scale, local_position,
        input  ready
    );

    modport sink (
        input  valid, node_index, parent_index, has_parent,
               local_rotation, local_scale, local_position,
        output ready
    );
endinterface

interface htc_world_if;
    import htc_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] out_index;
    logic [ROT_W-1:0] world_rotation;
    logic [SCL_W-1:0] world_scale;
    logic [POS_W-1:0] world_position;
    logic             norm_fault;

    modport source (
        output valid, out_index, world_rotation, world_scale, world_position, norm_fault,
        input  ready
    );

    modport sink (
        input  valid, out_index, world_rotation, world_scale, world_position, norm_fault,
        output ready
    );
endinterface

`default_nettype wire

[rtl/hierarchical_transform_compose_unit.sv]
// Composes scene-graph world transforms one node at a time. Each node word
// carries its slot, its parent's slot, a root flag and a local rotation
// (q1.14 quaternion), scale (q3.12) and position (q11.8). A root is stored and
// returned unchanged; a child reads its parent's world transform from the
// on-chip table, composes rotation, scale and position, writes the result
// back into its own slot and returns it. Parents must be sent before their
// children. Slot numbers wrap modulo MAX_NODES. A root goes from accept
// straight to the write state; a child passes through the 16-step compose
// sequencer, the bit-serial square root and the four divisions of the
// normalizer (18 quotient bits each, plus setup and store). One node is in
// flight at a time; the result register lets the next node start while a
// result word waits.
`default_nettype none

module hierarchical_transform_compose_unit #(
    parameter int MAX_NODES = htc_pkg::MAX_NODES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    htc_node_if.sink    node,
    htc_world_if.source world
);
    import htc_pkg::*;

    localparam int AW = $clog2(MAX_NODES);

    // index wrap, a constant lookup built at elaboration
    logic [AW-1:0] slot_map [1 << IDX_W];

    for (genvar g = 0; g < (1 << IDX_W); g++)
    begin : g_wrap
        assign slot_map[g] = AW'(g % MAX_NODES);
    end

    logic [AW-1:0] node_slot;
    logic [AW-1:0] parent_slot;

    assign node_slot   = slot_map[node.node_index];
    assign parent_slot = slot_map[node.parent_index];

    // transform table port signals
    logic          tbl_rd_en;
    logic [AW-1:0] tbl_rd_addr;
    xform_t        tbl_rd_data;
    logic          tbl_wr_en;
    logic [AW-1:0] tbl_wr_addr;
    xform_t        tbl_wr_data;

    // normalizer handshake
    norm_req_t     norm_req;
    norm_rsp_t     norm_rsp;

    // one wide entry per slot holds rotation, scale and position together;
    // reads only happen on accept and writes only at the end of a node, so
    // the two never meet and no forwarding is needed
    htc_table #(
        .MAX_NODES (MAX_NODES)
    ) u_table (
        .clk     (clk),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data)
    );

    // sequencer: quaternion product, scale, rotated position, result register
    htc_core #(
        .MAX_NODES (MAX_NODES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .node        (node),
        .world       (world),
        .node_slot   (node_slot),
        .parent_slot (parent_slot),
        .tbl_rd_en   (tbl_rd_en),
        .tbl_rd_addr (tbl_rd_addr),
        .tbl_rd_data (tbl_rd_data),
        .tbl_wr_en   (tbl_wr_en),
        .tbl_wr_addr (tbl_wr_addr),
        .tbl_wr_data (tbl_wr_data),
        .norm_req    (norm_req),
        .norm_rsp    (norm_rsp)
    );

    // quaternion normalizer: square root of the norm, then one divide per component
    htc_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (norm_req),
        .rsp   (norm_rsp)
    );

endmodule

`default_nettype wire

[rtl/htc_table.sv]
`default_nettype none

module htc_table #(
    parameter int MAX_NODES = htc_pkg::MAX_NODES_DEFAULT,
    localparam int AW = $clog2(MAX_NODES)
) (
    input  logic            clk,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output htc_pkg::xform_t rd_data,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  htc_pkg::xform_t wr_data
);
    import htc_pkg::*;

    xform_t mem [MAX_NODES];
    xform_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/htc_norm.sv]
`default_nettype none

module htc_norm (
    input  logic               clk,
    input  logic               rst_n,
    input  htc_pkg::norm_req_t req,
    output htc_pkg::norm_rsp_t rsp
);
    import htc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SQRT,
        S_DIV_SETUP,
        S_DIV,
        S_STORE
    } state_t;

    state_t                    state_reg;
    logic signed [COMP_W-1:0]  c_reg [4];
    logic [63:0]               n_reg;
    logic [63:0]               r_reg;
    logic [4:0]                k_reg;
    logic [31:0]               s_reg;
    logic [1:0]                comp_reg;
    logic [31:0]               rem_reg;
    logic [17:0]               dlo_reg;
    logic [17:0]               q_reg;
    logic [4:0]                cnt_reg;
    logic [ROT_W-1:0]          rot_reg;
    logic                      fault_reg;
    logic                      done_reg;

    logic [39:0]               n2;
    logic [63:0]               sq_bit;
    logic [63:0]               sq_trial;
    logic                      sq_take;
    logic [63:0]               r_next;
    logic signed [COMP_W-1:0]  c_sel;
    logic [COMP_W-1:0]         c_abs;
    logic [46:0]               dividend;
    logic [32:0]               div_t;
    logic                      div_take;
    logic signed [18:0]        q_signed;
    logic [15:0]               q_sat;

    always_comb
    begin
        n2 = '0;
        for (int i = 0; i < 4; i++)
        begin
            n2 = n2 + 40'(c_reg[i] * c_reg[i]);
        end
    end

    // one result bit per cycle, two radicand bits per cycle
    assign sq_bit   = 64'(1) << {k_reg, 1'b0};
    assign sq_trial = r_reg + sq_bit;
    assign sq_take  = (n_reg >= sq_trial);
    assign r_next   = sq_take ? ((r_reg >> 1) + sq_bit) : (r_reg >> 1);

    assign c_sel    = c_reg[comp_reg];
    assign c_abs    = c_sel[COMP_W-1] ? COMP_W'(-c_sel) : COMP_W'(c_sel);
    assign dividend = {1'b0, c_abs, 26'b0} + 47'(s_reg >> 1);

    assign div_t    = {rem_reg, dlo_reg[17]};
    assign div_take = (div_t >= {1'b0, s_reg});

    always_comb
    begin
        q_signed = c_sel[COMP_W-1] ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        if (q_signed > 19'sd32767)
        begin
            q_sat = 16'h7fff;
        end
        else if (q_signed < -19'sd32768)
        begin
            q_sat = 16'h8000;
        end
        else
        begin
            q_sat = q_signed[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            c_reg[i] <= $signed(req.comps[COMP_W*i +: COMP_W]);
                        end
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    if (n2 == '0)
                    begin
                        rot_reg   <= {48'b0, ROT_ONE};
                        fault_reg <= 1'b1;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        n_reg     <= {n2, 24'b0};
                        r_reg     <= '0;
                        k_reg     <= 5'd31;
                        fault_reg <= 1'b0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (sq_take)
                    begin
                        n_reg <= n_reg - sq_trial;
                    end
                    r_reg <= r_next;
                    k_reg <= k_reg - 5'd1;
                    if (k_reg == '0)
                    begin
                        s_reg     <= r_next[31:0];
                        comp_reg  <= '0;
                        state_reg <= S_DIV_SETUP;
                    end
                end
                S_DIV_SETUP:
                begin
                    rem_reg   <= 32'(dividend[46:18]);
                    dlo_reg   <= dividend[17:0];
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= div_take ? 32'(div_t - {1'b0, s_reg}) : div_t[31:0];
                    q_reg   <= {q_reg[16:0], div_take};
                    dlo_reg <= {dlo_reg[16:0], 1'b0};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd17)
                    begin
                        state_reg <= S_STORE;
                    end
                end
                S_STORE:
                begin
                    rot_reg[16*comp_reg +: 16] <= q_sat;
                    if (comp_reg == 2'd3)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= S_DIV_SETUP;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.fault = fault_reg;
    assign rsp.rot   = rot_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == S_IDLE)
        else $error("normalizer started while busy");

    a_fault_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && fault_reg) |-> rot_reg == {48'b0, ROT_ONE})
        else $error("zero-length fault without identity rotation");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> s_reg != '0)
        else $error("division by zero norm");

endmodule

`default_nettype wire

[rtl/htc_core.sv]
`default_nettype none

module htc_core #(
    parameter int MAX_NODES = htc_pkg::MAX_NODES_DEFAULT,
    localparam int AW = $clog2(MAX_NODES)
) (
    input  logic               clk,
    input  logic               rst_n,
    htc_node_if.sink           node,
    htc_world_if.source        world,
    input  logic [AW-1:0]      node_slot,
    input  logic [AW-1:0]      parent_slot,
    output logic               tbl_rd_en,
    output logic [AW-1:0]      tbl_rd_addr,
    input  htc_pkg::xform_t    tbl_rd_data,
    output logic               tbl_wr_en,
    output logic [AW-1:0]      tbl_wr_addr,
    output htc_pkg::xform_t    tbl_wr_data,
    output htc_pkg::norm_req_t norm_req,
    input  htc_pkg::norm_rsp_t norm_rsp
);
    import htc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_NORM,
        S_WRITE
    } state_t;

    localparam logic [3:0] LAST_STEP = 4'd15;

    state_t                   state_reg;
    logic [3:0]               step_reg;
    logic                     child_reg;
    logic [AW-1:0]            slot_reg;
    logic [ROT_W-1:0]         lr_reg;
    logic [SCL_W-1:0]         ls_reg;
    logic [POS_W-1:0]         lp_reg;
    logic signed [COMP_W-1:0] c_reg [4];
    logic [15:0]              ws_reg [3];
    logic signed [23:0]       v_reg [3];
    logic signed [26:0]       uv_reg [3];
    logic signed [29:0]       uuv_reg [3];
    logic [19:0]              wp_reg [3];
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_idx_reg;
    logic [ROT_W-1:0]         out_rot_reg;
    logic [SCL_W-1:0]         out_scl_reg;
    logic [POS_W-1:0]         out_pos_reg;
    logic                     out_fault_reg;

    logic                     accept;
    logic                     out_free;
    logic signed [15:0]       pq [4];
    logic signed [15:0]       lq [4];
    logic signed [15:0]       psc [3];
    logic signed [15:0]       lsc [3];
    logic signed [19:0]       ppos [3];
    logic signed [19:0]       lpos [3];
    logic [1:0]               k;

    logic signed [15:0]       da [4];
    logic signed [15:0]       db [4];
    logic [3:0]               dneg;
    logic signed [33:0]       dot_sum;
    logic signed [COMP_W-1:0] c_new;

    logic signed [32:0]       sp;
    logic signed [20:0]       sr;
    logic [15:0]              ws_new;
    logic signed [36:0]       vp;
    logic signed [23:0]       v_new;

    logic signed [15:0]       xa;
    logic signed [15:0]       ya;
    logic signed [26:0]       xb;
    logic signed [26:0]       yb;
    logic signed [44:0]       xd;
    logic signed [29:0]       x_new;

    logic signed [44:0]       tp;
    logic signed [30:0]       t_rnd;
    logic signed [33:0]       fs;
    logic [19:0]              wp_new;

    assign accept    = node.valid && node.ready;
    assign node.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || world.ready;

    // parent read issues with the accept; data holds until the next accept
    assign tbl_rd_en   = accept;
    assign tbl_rd_addr = parent_slot;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pq[i] = $signed(tbl_rd_data.rot[16*i +: 16]);
            lq[i] = $signed(lr_reg[16*i +: 16]);
        end
        for (int i = 0; i < 3; i++)
        begin
            psc[i]  = $signed(tbl_rd_data.scl[16*i +: 16]);
            lsc[i]  = $signed(ls_reg[16*i +: 16]);
            ppos[i] = $signed(tbl_rd_data.pos[20*i +: 20]);
            lpos[i] = $signed(lp_reg[20*i +: 20]);
        end
    end

    always_comb
    begin
        case (step_reg)
            4'd4, 4'd7, 4'd10, 4'd13: k = 2'd0;
            4'd5, 4'd8, 4'd11, 4'd14: k = 2'd1;
            4'd6, 4'd9, 4'd12, 4'd15: k = 2'd2;
            default:                  k = 2'd0;
        endcase
    end

    // hamilton product, one output component per step
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            da[i] = pq[i];
        end
        case (step_reg)
            4'd0:
            begin
                db[0] = lq[0]; db[1] = lq[1]; db[2] = lq[2]; db[3] = lq[3];
                dneg  = 4'b1110;
            end
            4'd1:
            begin
                db[0] = lq[1]; db[1] = lq[0]; db[2] = lq[3]; db[3] = lq[2];
                dneg  = 4'b1000;
            end
            4'd2:
            begin
                db[0] = lq[2]; db[1] = lq[3]; db[2] = lq[0]; db[3] = lq[1];
                dneg  = 4'b0010;
            end
            default:
            begin
                db[0] = lq[3]; db[1] = lq[2]; db[2] = lq[1]; db[3] = lq[0];
                dneg  = 4'b0100;
            end
        endcase
        dot_sum = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (dneg[i])
            begin
                dot_sum = dot_sum - 34'(da[i] * db[i]);
            end
            else
            begin
                dot_sum = dot_sum + 34'(da[i] * db[i]);
            end
        end
        c_new = COMP_W'((dot_sum + 34'sd8192) >>> 14);
    end

    // scale product and scaled local position
    always_comb
    begin
        sp = 33'(psc[k] * lsc[k]);
        sr = 21'((sp + 33'sd2048) >>> 12);
        if (sr > 21'sd32767)
        begin
            ws_new = 16'h7fff;
        end
        else if (sr < -21'sd32768)
        begin
            ws_new = 16'h8000;
        end
        else
        begin
            ws_new = sr[15:0];
        end
        vp    = 37'(psc[k] * lpos[k]);
        v_new = 24'((vp + 37'sd2048) >>> 12);
    end

    // cross product lane, q x v then q x (q x v)
    always_comb
    begin
        case (step_reg)
            4'd7:
            begin
                xa = pq[2]; xb = 27'(v_reg[2]); ya = pq[3]; yb = 27'(v_reg[1]);
            end
            4'd8:
            begin
                xa = pq[3]; xb = 27'(v_reg[0]); ya = pq[1]; yb = 27'(v_reg[2]);
            end
            4'd9:
            begin
                xa = pq[1]; xb = 27'(v_reg[1]); ya = pq[2]; yb = 27'(v_reg[0]);
            end
            4'd10:
            begin
                xa = pq[2]; xb = uv_reg[2]; ya = pq[3]; yb = uv_reg[1];
            end
            4'd11:
            begin
                xa = pq[3]; xb = uv_reg[0]; ya = pq[1]; yb = uv_reg[2];
            end
            default:
            begin
                xa = pq[1]; xb = uv_reg[1]; ya = pq[2]; yb = uv_reg[0];
            end
        endcase
        xd    = 45'(xa * xb) - 45'(ya * yb);
        x_new = 30'((xd + 45'sd8192) >>> 14);
    end

    // final sum per axis with saturation to q11.8
    always_comb
    begin
        tp     = 45'(17'(pq[0]) * 2 * uv_reg[k]);
        t_rnd  = 31'((tp + 45'sd8192) >>> 14);
        fs     = 34'(v_reg[k]) + 34'(t_rnd) + (34'(uuv_reg[k]) <<< 1) + 34'(ppos[k]);
        if (fs > 34'sd524287)
        begin
            wp_new = 20'h7ffff;
        end
        else if (fs < -34'sd524288)
        begin
            wp_new = 20'h80000;
        end
        else
        begin
            wp_new = fs[19:0];
        end
    end

    assign norm_req.start = (state_reg == S_CALC) && (step_reg == LAST_STEP);
    assign norm_req.comps = {c_reg[3], c_reg[2], c_reg[1], c_reg[0]};

    assign tbl_wr_en        = (state_reg == S_WRITE) && out_free;
    assign tbl_wr_addr      = slot_reg;
    assign tbl_wr_data.rot  = child_reg ? norm_rsp.rot : lr_reg;
    assign tbl_wr_data.scl  = child_reg ? {ws_reg[2], ws_reg[1], ws_reg[0]} : ls_reg;
    assign tbl_wr_data.pos  = child_reg ? {wp_reg[2], wp_reg[1], wp_reg[0]} : lp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        slot_reg  <= node_slot;
                        child_reg <= node.has_parent;
                        lr_reg    <= node.local_rotation;
                        ls_reg    <= node.local_scale;
                        lp_reg    <= node.local_position;
                        step_reg  <= '0;
                        state_reg <= node.has_parent ? S_CALC : S_WRITE;
                    end
                end
                S_CALC:
                begin
                    case (step_reg)
                        4'd0, 4'd1, 4'd2, 4'd3: c_reg[step_reg[1:0]] <= c_new;
                        4'd4, 4'd5, 4'd6:
                        begin
                            ws_reg[k] <= ws_new;
                            v_reg[k]  <= v_new;
                        end
                        4'd7, 4'd8, 4'd9:       uv_reg[k]  <= 27'(x_new);
                        4'd10, 4'd11, 4'd12:    uuv_reg[k] <= x_new;
                        default:                wp_reg[k]  <= wp_new;
                    endcase
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (norm_rsp.done)
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (tbl_wr_en)
            begin
                out_valid_reg <= 1'b1;
                out_idx_reg   <= IDX_W'(slot_reg);
                out_rot_reg   <= tbl_wr_data.rot;
                out_scl_reg   <= tbl_wr_data.scl;
                out_pos_reg   <= tbl_wr_data.pos;
                out_fault_reg <= child_reg && norm_rsp.fault;
            end
            else if (world.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign world.valid          = out_valid_reg;
    assign world.out_index      = out_idx_reg;
    assign world.world_rotation = out_rot_reg;
    assign world.world_scale    = out_scl_reg;
    assign world.world_position = out_pos_reg;
    assign world.norm_fault     = out_fault_reg;

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(tbl_wr_en && tbl_rd_en))
        else $error("table read and write in the same cycle");

    a_write_emits: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr_en |=> out_valid_reg)
        else $error("table write without a result word");

    a_norm_child_only: assert property (@(posedge clk) disable iff (!rst_n)
        norm_req.start |-> child_reg)
        else $error("normalizer started for a root node");

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps

// checks the world transform composer against a bit-exact model of the
// fixed-point math: roots pass straight through, children read their
// parent's world transform from a shadow of the slot table and compose it
module tb;
    import htc_pkg::*;

    localparam int RANDOM_WORDS = 1000;
    localparam int CALM_AFTER   = 900;   // no idling on either side from here on
    localparam int HOLD_AT      = 300;   // receiver holds off here
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_AT     = 600;   // sender waits for every result here
    localparam int TAIL_CYCLES  = 400;

    typedef longint vec3_t [3];

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [ROT_W-1:0] rot;
        logic [SCL_W-1:0] scl;
        logic [POS_W-1:0] pos;
        logic             fault;
    } world_word_t;

    // one row of directed stimulus; the expected word is typed in only
    // where it is obvious, otherwise the model below decides
    typedef struct {
        logic [IDX_W-1:0] node_idx;
        logic [IDX_W-1:0] parent_idx;
        logic             child;
        logic [ROT_W-1:0] rot;
        logic [SCL_W-1:0] scl;
        logic [POS_W-1:0] pos;
        bit               typed;
        logic [ROT_W-1:0] exp_rot;
        logic [SCL_W-1:0] exp_scl;
        logic [POS_W-1:0] exp_pos;
        logic             exp_fault;
    } node_row_t;

    localparam logic [ROT_W-1:0] ROT_IDENT = {48'h0, ROT_ONE};
    localparam logic [SCL_W-1:0] SCL_UNIT  = 48'h1000_1000_1000;
    localparam logic [ROT_W-1:0] ROT_MAX   = 64'h7fff_7fff_7fff_7fff;
    localparam logic [ROT_W-1:0] ROT_MIN   = 64'h8000_8000_8000_8000;
    localparam logic [SCL_W-1:0] SCL_MAX   = 48'h7fff_7fff_7fff;
    localparam logic [SCL_W-1:0] SCL_MIN   = 48'h8000_8000_8000;
    localparam logic [POS_W-1:0] POS_MAX   = 60'h7ffff_7ffff_7ffff;
    localparam logic [POS_W-1:0] POS_MIN   = 60'h80000_80000_80000;
    localparam logic [POS_W-1:0] POS_SOME  = 60'h00300_fff00_01280;
    localparam logic [ROT_W-1:0] ROT_TURN  = 64'h0000_2d41_0000_2d41;  // ~90 deg about y

    localparam int DIRECTED_ROWS = 14;
    node_row_t directed [DIRECTED_ROWS] = '{
        // roots: word returned unchanged
        '{8'd0,   8'd0,   1'b0, ROT_IDENT, SCL_UNIT, '0,       1'b1, ROT_IDENT, SCL_UNIT, '0,      1'b0},
        '{8'd255, 8'd0,   1'b0, ROT_MAX,   SCL_MAX,  POS_MAX,  1'b1, ROT_MAX,   SCL_MAX,  POS_MAX, 1'b0},
        '{8'd1,   8'd0,   1'b0, ROT_MIN,   SCL_MIN,  POS_MIN,  1'b1, ROT_MIN,   SCL_MIN,  POS_MIN, 1'b0},
        '{8'd2,   8'd0,   1'b0, '0,        SCL_UNIT, '0,       1'b1, '0,        SCL_UNIT, '0,      1'b0},
        // root with a parent slot that was never written: slot is ignored
        '{8'd7,   8'd200, 1'b0, ROT_TURN,  SCL_UNIT, POS_SOME, 1'b1, ROT_TURN,  SCL_UNIT, POS_SOME, 1'b0},
        // zero-length product: identity rotation and the fault flag
        '{8'd3,   8'd2,   1'b1, ROT_TURN,  SCL_UNIT, POS_SOME, 1'b1, ROT_IDENT, SCL_UNIT, POS_SOME, 1'b1},
        // saturation at both ends
        '{8'd4,   8'd255, 1'b1, ROT_MAX,   SCL_MAX,  POS_MAX,  1'b0, '0, '0, '0, 1'b0},
        '{8'd5,   8'd1,   1'b1, ROT_MIN,   SCL_MIN,  POS_MIN,  1'b0, '0, '0, '0, 1'b0},
        '{8'd8,   8'd255, 1'b1, ROT_MIN,   SCL_MIN,  POS_MIN,  1'b0, '0, '0, '0, 1'b0},
        // plain rotation under an identity parent, then under a turned parent
        '{8'd6,   8'd0,   1'b1, ROT_TURN,  SCL_UNIT, POS_SOME, 1'b0, '0, '0, '0, 1'b0},
        '{8'd9,   8'd7,   1'b1, ROT_TURN,  SCL_UNIT, POS_SOME, 1'b0, '0, '0, '0, 1'b0},
        // parent is the node itself: old entry is read first
        '{8'd6,   8'd6,   1'b1, ROT_TURN,  SCL_MAX,  POS_MAX,  1'b0, '0, '0, '0, 1'b0},
        // child of the faulted node, and a chain down from it
        '{8'd10,  8'd3,   1'b1, ROT_MAX,   SCL_UNIT, POS_MIN,  1'b0, '0, '0, '0, 1'b0},
        '{8'd11,  8'd10,  1'b1, ROT_IDENT, SCL_MIN,  POS_SOME, 1'b0, '0, '0, '0, 1'b0}
    };

    logic clk;
    logic rst_n;

    htc_node_if  node ();
    htc_world_if world ();

    hierarchical_transform_compose_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .node  (node.sink),
        .world (world.source)
    );

    // shadow of the slot table, plus which slots hold a real entry
    logic [ROT_W-1:0] rot_shadow [256];
    logic [SCL_W-1:0] scl_shadow [256];
    logic [POS_W-1:0] pos_shadow [256];
    bit               slot_live  [256];
    byte unsigned     live_slots [$];

    world_word_t pending_words [$];

    int  mismatches;
    int  words_sent;
    int  roots_sent;
    int  children_sent;
    int  words_checked;
    int  faults_checked;
    bit  idling_on;
    bit  hold_request;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // fixed-point helpers
    // ---------------------------------------------------------------

    // add half an lsb, then floor shift
    function automatic longint round_shift(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // q x v with each component rounded back by 14 bits
    function automatic vec3_t cross_round(vec3_t q, vec3_t v);
        vec3_t o;
        o[0] = round_shift(q[1] * v[2] - q[2] * v[1], 14);
        o[1] = round_shift(q[2] * v[0] - q[0] * v[2], 14);
        o[2] = round_shift(q[0] * v[1] - q[1] * v[0], 14);
        return o;
    endfunction

    // ---------------------------------------------------------------
    // composes one node against the shadow table and stores the result
    // ---------------------------------------------------------------
    function automatic world_word_t compose_world(logic [IDX_W-1:0] idx,
                                                  logic [IDX_W-1:0] par,
                                                  logic child,
                                                  logic [ROT_W-1:0] lr,
                                                  logic [SCL_W-1:0] ls,
                                                  logic [POS_W-1:0] lp);
        world_word_t w;
        longint pq [4];
        longint lq [4];
        longint c [4];
        longint psc [3];
        longint lsc [3];
        longint ppos [3];
        longint lpos [3];
        vec3_t v;
        vec3_t qv;
        vec3_t uv;
        vec3_t uuv;
        longint unsigned n2;
        longint unsigned s;
        longint unsigned mag;
        longint o;
        longint r;
        w.idx = idx;
        w.rot = lr;
        w.scl = ls;
        w.pos = lp;
        w.fault = 1'b0;
        if (child)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pq[i] = longint'($signed(rot_shadow[par][16*i +: 16]));
                lq[i] = longint'($signed(lr[16*i +: 16]));
            end
            for (int i = 0; i < 3; i++)
            begin
                psc[i]  = longint'($signed(scl_shadow[par][16*i +: 16]));
                lsc[i]  = longint'($signed(ls[16*i +: 16]));
                ppos[i] = longint'($signed(pos_shadow[par][20*i +: 20]));
                lpos[i] = longint'($signed(lp[20*i +: 20]));
            end
            // hamilton product parent * local
            c[0] = round_shift(pq[0]*lq[0] - pq[1]*lq[1] - pq[2]*lq[2] - pq[3]*lq[3], 14);
            c[1] = round_shift(pq[0]*lq[1] + pq[1]*lq[0] + pq[2]*lq[3] - pq[3]*lq[2], 14);
            c[2] = round_shift(pq[0]*lq[2] - pq[1]*lq[3] + pq[2]*lq[0] + pq[3]*lq[1], 14);
            c[3] = round_shift(pq[0]*lq[3] + pq[1]*lq[2] - pq[2]*lq[1] + pq[3]*lq[0], 14);
            n2 = 0;
            for (int i = 0; i < 4; i++)
                n2 += longint'(c[i] * c[i]);
            w.rot = '0;
            if (n2 == 0)
            begin
                w.rot = ROT_IDENT;
                w.fault = 1'b1;
            end
            else
            begin
                s = int_sqrt(n2 << 24);
                for (int i = 0; i < 4; i++)
                begin
                    mag = longint'(c[i] < 0 ? -c[i] : c[i]) << 26;
                    o = longint'((mag + s / 2) / s);
                    if (c[i] < 0)
                        o = -o;
                    w.rot[16*i +: 16] = 16'(clamp(o, 16));
                end
            end
            for (int i = 0; i < 3; i++)
                w.scl[16*i +: 16] = 16'(clamp(round_shift(psc[i] * lsc[i], 12), 16));
            for (int i = 0; i < 3; i++)
            begin
                v[i]  = round_shift(psc[i] * lpos[i], 12);
                qv[i] = pq[i+1];
            end
            uv  = cross_round(qv, v);
            uuv = cross_round(qv, uv);
            for (int i = 0; i < 3; i++)
            begin
                r = v[i] + round_shift(2 * pq[0] * uv[i], 14) + 2 * uuv[i] + ppos[i];
                w.pos[20*i +: 20] = 20'(clamp(r, 20));
            end
        end
        rot_shadow[idx] = w.rot;
        scl_shadow[idx] = w.scl;
        pos_shadow[idx] = w.pos;
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------
    task automatic send_node(logic [IDX_W-1:0] idx, logic [IDX_W-1:0] par, logic child,
                             logic [ROT_W-1:0] lr, logic [SCL_W-1:0] ls,
                             logic [POS_W-1:0] lp, bit typed, world_word_t typed_word);
        world_word_t predicted;
        // occasional random gap before the word while idling is on
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            node.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        node.valid          <= 1'b1;
        node.node_index     <= idx;
        node.parent_index   <= par;
        node.has_parent     <= child;
        node.local_rotation <= lr;
        node.local_scale    <= ls;
        node.local_position <= lp;
        do
            @(posedge clk);
        while (!node.ready);
        // accepted at this edge
        predicted = compose_world(idx, par, child, lr, ls, lp);
        pending_words.push_back(typed ? typed_word : predicted);
        if (!slot_live[idx])
        begin
            slot_live[idx] = 1'b1;
            live_slots.push_back(idx);
        end
        words_sent++;
        if (child)
            children_sent++;
        else
            roots_sent++;
    endtask

    // random field values: mostly well-scaled, some raw bit patterns
    function automatic logic [ROT_W-1:0] pick_rotation();
        logic [ROT_W-1:0] q;
        case ($urandom_range(0, 19))
            0: q = '0;
            1, 2, 3, 4: q = {$urandom, $urandom};
            default:
                for (int i = 0; i < 4; i++)
                    q[16*i +: 16] = 16'($urandom_range(0, 32768) - 16384);
        endcase
        return q;
    endfunction

    function automatic logic [SCL_W-1:0] pick_scale();
        logic [SCL_W-1:0] sc;
        if ($urandom_range(0, 4) == 0)
            sc = SCL_W'({$urandom, $urandom});
        else
            for (int i = 0; i < 3; i++)
                sc[16*i +: 16] = 16'($urandom_range(0, 16384) - 8192);
        return sc;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        logic [POS_W-1:0] p;
        if ($urandom_range(0, 4) == 0)
            p = POS_W'({$urandom, $urandom});
        else
            for (int i = 0; i < 3; i++)
                p[20*i +: 20] = 20'($urandom_range(0, 65536) - 32768);
        return p;
    endfunction

    initial
    begin
        world_word_t tw;
        logic [IDX_W-1:0] par;
        bit child;
        rst_n <= 1'b0;
        node.valid          <= 1'b0;
        node.node_index     <= '0;
        node.parent_index   <= '0;
        node.has_parent     <= 1'b0;
        node.local_rotation <= '0;
        node.local_scale    <= '0;
        node.local_position <= '0;
        idling_on = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        foreach (directed[i])
        begin
            tw.idx   = directed[i].node_idx;
            tw.rot   = directed[i].exp_rot;
            tw.scl   = directed[i].exp_scl;
            tw.pos   = directed[i].exp_pos;
            tw.fault = directed[i].exp_fault;
            send_node(directed[i].node_idx, directed[i].parent_idx, directed[i].child,
                      directed[i].rot, directed[i].scl, directed[i].pos,
                      directed[i].typed, tw);
        end

        // random part: mostly children of live slots, some fresh roots
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == HOLD_AT)
                hold_request = 1'b1;
            if (n == DRAIN_AT)
            begin
                // stop and let everything come back
                node.valid <= 1'b0;
                while (pending_words.size() != 0)
                    @(posedge clk);
            end
            if (n == CALM_AFTER)
                idling_on = 1'b0;
            child = ($urandom_range(0, 4) != 0);
            par = child ? live_slots[$urandom_range(0, live_slots.size() - 1)]
                        : IDX_W'($urandom);
            send_node(IDX_W'($urandom), par, child, pick_rotation(), pick_scale(),
                      pick_position(), 1'b0, tw);
        end
        node.valid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d node words (%0d roots, %0d children), checked %0d world words",
                 words_sent, roots_sent, children_sent, words_checked);
        $display("zero-length faults seen %0d, mismatches %0d", faults_checked, mismatches);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------
    // receiver: random stalls, one long hold-off, none near the end
    // ---------------------------------------------------------------
    initial
    begin
        world.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                world.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                world.ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(posedge clk);
            end
            else
                world.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // checker: oldest expected word against each returned word
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        world_word_t e;
        if (rst_n && world.valid && world.ready)
        begin
            if (pending_words.size() == 0)
                report_mismatch("unexpected world word, index", 64'(world.out_index), '0);
            else
            begin
                e = pending_words.pop_front();
                words_checked++;
                if (e.fault)
                    faults_checked++;
                if (world.out_index !== e.idx)
                    report_mismatch("out_index", 64'(world.out_index), 64'(e.idx));
                if (world.world_rotation !== e.rot)
                    report_mismatch("world_rotation", world.world_rotation, e.rot);
                if (world.world_scale !== e.scl)
                    report_mismatch("world_scale", 64'(world.world_scale), 64'(e.scl));
                if (world.world_position !== e.pos)
                    report_mismatch("world_position", 64'(world.world_position),
                                    64'(e.pos));
                if (world.norm_fault !== e.fault)
                    report_mismatch("norm_fault", 64'(world.norm_fault), 64'(e.fault));
            end
        end
    end

    // watchdog, well beyond the slowest legal run
    initial
    begin
        #5ms;
        $display("timeout with %0d words outstanding", pending_words.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
